// ===== rtl/ipsc_pkg.sv =====
// ----------------------------------------------------------------------------
// ipsc_pkg
// Types and constants shared by the inactivity power state controller.
// ----------------------------------------------------------------------------
package ipsc_pkg;

   localparam int unsigned TIME_WIDTH    = 32;
   localparam int unsigned ADC_WIDTH     = 12;
   localparam int unsigned PCT_WIDTH     = 7;
   localparam int unsigned MODE_WIDTH    = 2;
   localparam int unsigned CHARGE_WIDTH  = 2;
   localparam int unsigned CSR_IDX_WIDTH = 2;

   // power mode codes
   localparam logic [MODE_WIDTH-1:0] MODE_ACTIVE = 2'd0;
   localparam logic [MODE_WIDTH-1:0] MODE_IDLE   = 2'd1;
   localparam logic [MODE_WIDTH-1:0] MODE_SLEEP  = 2'd2;

   // charge status codes
   localparam logic [CHARGE_WIDTH-1:0] CHG_NONE     = 2'd0;
   localparam logic [CHARGE_WIDTH-1:0] CHG_CHARGING = 2'd1;
   localparam logic [CHARGE_WIDTH-1:0] CHG_CHARGED  = 2'd2;

   // request kinds
   localparam logic KIND_UPDATE   = 1'b0;
   localparam logic KIND_ACTIVITY = 1'b1;

   // configuration register indexes
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_IDLE_TIMEOUT  = 2'd0;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_SLEEP_TIMEOUT = 2'd1;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_CHARGE_EN     = 2'd2;

   // configuration reset values
   localparam logic [TIME_WIDTH-1:0] IDLE_TIMEOUT_RESET  = 32'd30000;
   localparam logic [TIME_WIDTH-1:0] SLEEP_TIMEOUT_RESET = 32'd300000;
   localparam logic                  CHARGE_EN_RESET     = 1'b1;

   // battery conversion
   localparam logic [ADC_WIDTH-1:0] ADC_ZERO_LIMIT  = 12'd1986;
   localparam logic [ADC_WIDTH-1:0] ADC_FULL_LIMIT  = 12'd2607;
   localparam logic [PCT_WIDTH-1:0] PCT_FULL        = 7'd100;
   localparam logic [PCT_WIDTH-1:0] PCT_EMPTY       = 7'd0;
   localparam logic [PCT_WIDTH-1:0] CHARGED_PERCENT = 7'd95;

   typedef struct packed {
      logic                  kind;
      logic [TIME_WIDTH-1:0] time_ms;
      logic [ADC_WIDTH-1:0]  adc_sample;
      logic                  usb_pin_low;
      logic                  charge_pin_low;
   } req_type;

   typedef struct packed {
      logic [MODE_WIDTH-1:0]   power_mode;
      logic [PCT_WIDTH-1:0]    battery_percent;
      logic [CHARGE_WIDTH-1:0] charge_state;
      logic                    usb_present;
   } rsp_type;

endpackage

// ===== rtl/ipsc_battery.sv =====
// ----------------------------------------------------------------------------
// ipsc_battery
// Battery ADC sample to percent, and charge status from the new percent.
// ----------------------------------------------------------------------------
module ipsc_battery (
   input  logic [ipsc_pkg::ADC_WIDTH-1:0]    adc_sample,
   input  logic                              usb_pin_low,
   input  logic                              charge_pin_low,
   input  logic                              charge_enable,
   output logic [ipsc_pkg::PCT_WIDTH-1:0]    percent,
   output logic [ipsc_pkg::CHARGE_WIDTH-1:0] charge_state
);
   import ipsc_pkg::*;

   // 660*adc - 1310400 rewritten as 660*(adc - 1986) + 360
   localparam logic [18:0] PCT_SLOPE = 19'd660;
   localparam logic [18:0] PCT_BIAS  = 19'd360;

   logic [ADC_WIDTH-1:0] adc_offset;
   logic [18:0]          scaled;
   logic [19:0]          recip_sum;
   logic [PCT_WIDTH-1:0] pct_linear;

   assign adc_offset = adc_sample - ADC_ZERO_LIMIT;
   assign scaled     = {9'd0, adc_offset[9:0]} * PCT_SLOPE + PCT_BIAS;

   // divide by 4095: exact for quotients up to 127, the most that the 7-bit result holds
   assign recip_sum  = {1'b0, scaled} + {13'd0, scaled[18:12]} + 20'd1;
   assign pct_linear = recip_sum[18:12];

   always_comb begin
      if (adc_sample < ADC_ZERO_LIMIT) begin
         percent = PCT_EMPTY;
      end else if (adc_sample >= ADC_FULL_LIMIT) begin
         percent = PCT_FULL;
      end else begin
         percent = pct_linear;
      end
   end

   always_comb begin
      if (!usb_pin_low) begin
         charge_state = CHG_NONE;
      end else if (charge_pin_low && charge_enable) begin
         charge_state = CHG_CHARGING;
      end else if (percent >= CHARGED_PERCENT) begin
         charge_state = CHG_CHARGED;
      end else begin
         charge_state = CHG_NONE;
      end
   end

endmodule

// ===== rtl/inactivity_power_state_controller.sv =====
// ----------------------------------------------------------------------------
// inactivity_power_state_controller
// Power manager: inactivity timeouts move the mode from active to idle to
// sleep, activity requests wake it, and update requests refresh the battery
// percent, USB presence and charge status. One request is taken per clock
// cycle while the input register is empty or the response register is free
// or draining; each gives one response via the input register and then the
// response register, with mode and battery state updated in the single step
// between them. A stalled response holds only the input register's request.
// ----------------------------------------------------------------------------
module inactivity_power_state_controller (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  ipsc_pkg::req_type                    req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output ipsc_pkg::rsp_type                    rsp_data,
   input  logic                                 csr_we,
   input  logic [ipsc_pkg::CSR_IDX_WIDTH-1:0]   csr_index,
   input  logic [ipsc_pkg::TIME_WIDTH-1:0]      csr_wdata
);
   import ipsc_pkg::*;

   // configuration
   logic [TIME_WIDTH-1:0] idle_timeout_ff;
   logic [TIME_WIDTH-1:0] sleep_timeout_ff;
   logic                  charge_en_ff;

   // pipeline
   logic    in_valid_ff;
   req_type in_ff;
   logic    rsp_valid_ff;
   rsp_type rsp_ff;
   logic    advance;
   logic    fire;

   // block state
   logic [MODE_WIDTH-1:0]   mode_ff, mode_in;
   logic [TIME_WIDTH-1:0]   last_act_ff, last_act_in;
   logic [PCT_WIDTH-1:0]    pct_ff, pct_in;
   logic [CHARGE_WIDTH-1:0] charge_ff, charge_in;
   logic                    usb_ff, usb_in;

   logic [PCT_WIDTH-1:0]    new_pct;
   logic [CHARGE_WIDTH-1:0] new_charge;
   logic [TIME_WIDTH-1:0]   elapsed;

   // Advance the input register whenever the response register is free or
   // being drained this cycle.
   assign advance   = !rsp_valid_ff || rsp_ready;
   assign fire      = in_valid_ff && advance;
   assign req_ready = !in_valid_ff || advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Configuration writes; indexes beyond the list are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         idle_timeout_ff  <= IDLE_TIMEOUT_RESET;
         sleep_timeout_ff <= SLEEP_TIMEOUT_RESET;
         charge_en_ff     <= CHARGE_EN_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_IDLE_TIMEOUT:  idle_timeout_ff  <= csr_wdata;
            CSR_SLEEP_TIMEOUT: sleep_timeout_ff <= csr_wdata;
            CSR_CHARGE_EN:     charge_en_ff     <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   // Battery conversion and charge status for the held request.
   ipsc_battery u_battery (
      .adc_sample     (in_ff.adc_sample),
      .usb_pin_low    (in_ff.usb_pin_low),
      .charge_pin_low (in_ff.charge_pin_low),
      .charge_enable  (charge_en_ff),
      .percent        (new_pct),
      .charge_state   (new_charge)
   );

   // Wrapping inactivity time, used as is when the clock runs backwards.
   assign elapsed = in_ff.time_ms - last_act_ff;

   always_comb begin
      mode_in     = mode_ff;
      last_act_in = last_act_ff;
      pct_in      = pct_ff;
      charge_in   = charge_ff;
      usb_in      = usb_ff;
      if (in_ff.kind == KIND_ACTIVITY) begin
         // record activity; only sleep is woken, idle stays idle
         last_act_in = in_ff.time_ms;
         if (mode_ff == MODE_SLEEP) begin
            mode_in = MODE_ACTIVE;
         end
      end else begin
         pct_in    = new_pct;
         charge_in = new_charge;
         usb_in    = in_ff.usb_pin_low;
         case (mode_ff)
            MODE_ACTIVE: begin
               if (elapsed > idle_timeout_ff) begin
                  mode_in = MODE_IDLE;
               end
            end
            MODE_IDLE: begin
               if (elapsed > sleep_timeout_ff) begin
                  mode_in = MODE_SLEEP;
               end
            end
            default: begin
               // sleep holds; the unused code holds as well
            end
         endcase
      end
   end

   // Control and state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         mode_ff      <= MODE_ACTIVE;
         last_act_ff  <= '0;
         pct_ff       <= PCT_FULL;
         charge_ff    <= CHG_NONE;
         usb_ff       <= 1'b0;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            rsp_valid_ff <= in_valid_ff;
         end
         if (fire) begin
            mode_ff     <= mode_in;
            last_act_ff <= last_act_in;
            pct_ff      <= pct_in;
            charge_ff   <= charge_in;
            usb_ff      <= usb_in;
         end
      end
   end

   // Payload registers: capture on acceptance, hold while stalled.
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_ff <= req_data;
      end
      if (fire) begin
         rsp_ff.power_mode      <= mode_in;
         rsp_ff.battery_percent <= pct_in;
         rsp_ff.charge_state    <= charge_in;
         rsp_ff.usb_present     <= usb_in;
      end
   end

`ifndef SYNTHESIS
   // A response appears only from a request held in the input register.
   a_rsp_from_request: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(in_valid_ff))
      else $error("response raised without a held request");

   // An activity request never leaves the block asleep.
   a_activity_wakes: assert property (@(posedge clock) disable iff (reset)
      (fire && in_ff.kind == KIND_ACTIVITY) |=> mode_ff != MODE_SLEEP)
      else $error("activity request left the mode asleep");

   // Charged needs USB and a high enough percent.
   a_charged_consistent: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.charge_state == CHG_CHARGED) |->
         (rsp_ff.usb_present && rsp_ff.battery_percent >= CHARGED_PERCENT))
      else $error("charged status without USB or full enough battery");

   // Percent never leaves its range.
   a_percent_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_ff.battery_percent <= PCT_FULL)
      else $error("battery percent above full scale");
`endif

endmodule
